// ===== rtl/resp_stream_parser_core_defines.svh =====
// Assertion macros used by the parser back end (rsp_back).
`ifndef RESP_STREAM_PARSER_CORE_DEFINES_SVH
`define RESP_STREAM_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RSP_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rsp: same-cycle property violated");
`define RSP_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rsp: next-cycle property violated");
`else
`define RSP_ASSERT_IMP(label, pre, post)
`define RSP_ASSERT_NXT(label, pre, post)
`endif

`endif

// ===== rtl/rsp_pkg.sv =====
// Types, codes and constants of the RESP stream parser.
package rsp_pkg;

    localparam int LEN_BITS_DEF   = 30;
    localparam int COUNT_BITS_DEF = 21;

    localparam int BYTE_W        = 8;
    localparam int KIND_W        = 2;
    localparam int MAX_BULK_W    = 30;
    localparam int MAX_ARRAY_W   = 21;
    localparam int ARRAY_COUNT_W = 21;
    localparam int CFG_DATA_W    = 30;
    localparam int CFG_IDX_W     = 1;

    localparam logic [MAX_BULK_W-1:0]  MAX_BULK_RST  = 30'd536870912;
    localparam logic [MAX_ARRAY_W-1:0] MAX_ARRAY_RST = 21'd1048576;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK_LEN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARRAY_COUNT = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [BYTE_W-1:0] ASC_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] ASC_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] ASC_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] ASC_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] ASC_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] ASC_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] ASC_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] ASC_NINE   = 8'h39;

    typedef enum logic [2:0] {
        CH_PLUS,
        CH_MINUS,
        CH_DOLLAR,
        CH_STAR,
        CH_CR,
        CH_LF,
        CH_DIGIT,
        CH_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_ERROR  = 2'd1,
        KIND_BULK   = 2'd2,
        KIND_NULL   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LINE_FIRST,
        PH_LINE,
        PH_LINE_LF,
        PH_NUM_FIRST,
        PH_NUM_SIGN,
        PH_NUM,
        PH_NUM_LF,
        PH_BULK_FIRST,
        PH_BULK,
        PH_BULK_LF
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        char_class_t       cls;
        logic [3:0]        digit;
    } rsp_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]        data;
        logic                     payload_valid;
        kind_t                    kind;
        logic                     elem_start;
        logic                     elem_end;
        logic                     in_array_item;
        logic                     array_header;
        logic [ARRAY_COUNT_W-1:0] array_count;
        logic                     msg_end;
        logic                     bad_frame;
    } rsp_result_t;

endpackage

// ===== rtl/rsp_in_if.sv =====
// Byte channel into the parser.
interface rsp_in_if;
    logic                       valid;
    logic                       ready;
    logic [rsp_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/rsp_out_if.sv =====
// Result channel out of the parser.
interface rsp_out_if;
    logic                              valid;
    logic                              ready;
    logic [rsp_pkg::BYTE_W-1:0]        out_byte;
    logic                              payload_valid;
    logic [rsp_pkg::KIND_W-1:0]        elem_kind;
    logic                              elem_start;
    logic                              elem_end;
    logic                              in_array_item;
    logic                              array_header;
    logic [rsp_pkg::ARRAY_COUNT_W-1:0] array_count;
    logic                              msg_end;
    logic                              bad_frame;

    modport source (output valid, output out_byte, output payload_valid, output elem_kind,
                    output elem_start, output elem_end, output in_array_item,
                    output array_header, output array_count, output msg_end,
                    output bad_frame, input ready);
    modport sink   (input valid, input out_byte, input payload_valid, input elem_kind,
                    input elem_start, input elem_end, input in_array_item,
                    input array_header, input array_count, input msg_end,
                    input bad_frame, output ready);
endinterface

// ===== rtl/rsp_front.sv =====
// Front stage: takes raw bytes and registers them with their character class.
module rsp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rsp_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_valid,
    output logic                       in_ready,
    output rsp_pkg::rsp_word_t         word,
    output logic                       word_valid,
    input  logic                       word_ready
);
    import rsp_pkg::*;

    rsp_word_t word_reg;
    rsp_word_t word_next;
    logic      valid_reg;
    logic      is_digit;

    assign is_digit = (in_byte >= ASC_ZERO) && (in_byte <= ASC_NINE);

    always_comb
    begin
        word_next.data  = in_byte;
        word_next.digit = is_digit ? in_byte[3:0] : 4'd0;
        priority if (is_digit)
        begin
            word_next.cls = CH_DIGIT;
        end
        else if (in_byte == ASC_PLUS)
        begin
            word_next.cls = CH_PLUS;
        end
        else if (in_byte == ASC_MINUS)
        begin
            word_next.cls = CH_MINUS;
        end
        else if (in_byte == ASC_DOLLAR)
        begin
            word_next.cls = CH_DOLLAR;
        end
        else if (in_byte == ASC_STAR)
        begin
            word_next.cls = CH_STAR;
        end
        else if (in_byte == ASC_CR)
        begin
            word_next.cls = CH_CR;
        end
        else if (in_byte == ASC_LF)
        begin
            word_next.cls = CH_LF;
        end
        else
        begin
            word_next.cls = CH_OTHER;
        end
    end

    assign in_ready   = !valid_reg || word_ready;
    assign word       = word_reg;
    assign word_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end
endmodule

// ===== rtl/rsp_queue.sv =====
// Short queue of classified words between front and back.
module rsp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  rsp_pkg::rsp_word_t push_word,
    input  logic               push_valid,
    output logic               push_ready,
    output rsp_pkg::rsp_word_t pop_word,
    output logic               pop_valid,
    input  logic               pop_ready
);
    import rsp_pkg::*;

    rsp_word_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end
endmodule

// ===== rtl/rsp_back.sv =====
// Back stage: phase machine, length counters, limits and result register.
`include "resp_stream_parser_core_defines.svh"

module rsp_back #(
    parameter int LEN_BITS   = rsp_pkg::LEN_BITS_DEF,
    parameter int COUNT_BITS = rsp_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rsp_pkg::rsp_word_t             word,
    input  logic                           word_valid,
    output logic                           word_ready,
    output rsp_pkg::rsp_result_t           result,
    output logic                           result_valid,
    input  logic                           result_ready,
    input  logic                           cfg_we,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rsp_pkg::*;

    localparam int MW = LEN_BITS + 4;
    localparam logic [63:0] LEN_MASK = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [63:0] CNT_MASK = (64'd1 << COUNT_BITS) - 64'd1;

    phase_t                 phase_reg, phase_next;
    logic [LEN_BITS-1:0]    accum_reg, accum_next;
    logic                   neg_reg, neg_next;
    logic [LEN_BITS-1:0]    bulk_rem_reg, bulk_rem_next;
    logic [COUNT_BITS-1:0]  items_reg, items_next;
    logic                   inside_reg, inside_next;
    kind_t                  kind_reg, kind_next;
    logic                   hdr_reg, hdr_next;
    logic [MAX_BULK_W-1:0]  max_bulk_reg;
    logic [MAX_ARRAY_W-1:0] max_array_reg;
    rsp_result_t            res_reg, res_next;
    logic                   res_valid_reg;

    logic                   pop;
    logic                   fail;
    logic [MW-1:0]          acc_wide;
    logic [MW-1:0]          acc_x10;
    logic [63:0]            lim;
    logic                   over;
    logic [63:0]            cnt64;
    logic                   cnt_zero;
    logic [COUNT_BITS-1:0]  items_dec;
    logic                   fin_msg;
    logic                   bulk_nz;
    logic                   num_phase;

    assign word_ready   = !res_valid_reg || result_ready;
    assign pop          = word_valid && word_ready;
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

    // accum * 10 + digit, checked against the active limit
    always_comb
    begin
        acc_wide = MW'(accum_reg);
        acc_x10  = (acc_wide << 3) + (acc_wide << 1) + MW'(word.digit);
        priority if (hdr_reg)
        begin
            lim = 64'(max_array_reg) & CNT_MASK & LEN_MASK;
        end
        else if (neg_reg)
        begin
            lim = 64'd1 & LEN_MASK;
        end
        else
        begin
            lim = 64'(max_bulk_reg) & LEN_MASK;
        end
        over = 64'(acc_x10) > lim;
    end

    assign cnt64     = 64'(accum_reg) & CNT_MASK;
    assign cnt_zero  = cnt64 == 64'd0;
    assign items_dec = items_reg - COUNT_BITS'(1);
    assign fin_msg   = inside_reg ? (items_dec == '0) : 1'b1;
    assign bulk_nz   = bulk_rem_reg != '0;
    assign num_phase = (phase_reg == PH_NUM_FIRST) || (phase_reg == PH_NUM)
                       || (phase_reg == PH_NUM_LF);

    // next phase and framing check
    always_comb
    begin
        fail       = 1'b0;
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (word.cls == CH_PLUS || word.cls == CH_MINUS)
                begin
                    phase_next = PH_LINE_FIRST;
                end
                else if (word.cls == CH_DOLLAR || (word.cls == CH_STAR && !inside_reg))
                begin
                    phase_next = PH_NUM_FIRST;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_LINE_FIRST, PH_LINE:
            begin
                if (word.cls == CH_CR)
                begin
                    phase_next = PH_LINE_LF;
                end
                else if (word.cls == CH_LF)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    phase_next = PH_LINE;
                end
            end
            PH_LINE_LF, PH_BULK_LF:
            begin
                fail       = word.cls != CH_LF;
                phase_next = PH_IDLE;
            end
            PH_NUM_FIRST:
            begin
                if (word.cls == CH_MINUS)
                begin
                    fail       = hdr_reg;
                    phase_next = PH_NUM_SIGN;
                end
                else if (word.cls == CH_DIGIT)
                begin
                    fail       = over;
                    phase_next = PH_NUM;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_NUM_SIGN, PH_NUM:
            begin
                if (word.cls == CH_DIGIT)
                begin
                    fail       = over;
                    phase_next = PH_NUM;
                end
                else if (word.cls == CH_CR && phase_reg == PH_NUM)
                begin
                    phase_next = PH_NUM_LF;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_NUM_LF:
            begin
                if (word.cls != CH_LF)
                begin
                    fail = 1'b1;
                end
                else if (hdr_reg)
                begin
                    phase_next = PH_IDLE;
                end
                else if (neg_reg)
                begin
                    fail       = accum_reg != LEN_BITS'(1);
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_BULK_FIRST;
                end
            end
            PH_BULK_FIRST, PH_BULK:
            begin
                if (bulk_nz)
                begin
                    phase_next = PH_BULK;
                end
                else if (word.cls == CH_CR)
                begin
                    phase_next = PH_BULK_LF;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            default:
            begin
                fail = 1'b1;
            end
        endcase
        if (fail)
        begin
            phase_next = PH_IDLE;
        end
    end

    // counters and element context
    always_comb
    begin
        accum_next    = accum_reg;
        neg_next      = neg_reg;
        bulk_rem_next = bulk_rem_reg;
        items_next    = items_reg;
        inside_next   = inside_reg;
        kind_next     = kind_reg;
        hdr_next      = hdr_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (word.cls == CH_PLUS)
                begin
                    kind_next = KIND_SIMPLE;
                end
                else if (word.cls == CH_MINUS)
                begin
                    kind_next = KIND_ERROR;
                end
                else
                begin
                    kind_next  = (word.cls == CH_DOLLAR) ? KIND_BULK : KIND_SIMPLE;
                    hdr_next   = word.cls != CH_DOLLAR;
                    accum_next = '0;
                    neg_next   = 1'b0;
                end
            end
            PH_NUM_FIRST, PH_NUM_SIGN, PH_NUM:
            begin
                if (word.cls == CH_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if (word.cls == CH_DIGIT)
                begin
                    accum_next = LEN_BITS'(acc_x10);
                end
            end
            PH_NUM_LF:
            begin
                if (hdr_reg)
                begin
                    hdr_next = 1'b0;
                    if (!cnt_zero)
                    begin
                        inside_next = 1'b1;
                        items_next  = COUNT_BITS'(cnt64);
                    end
                end
                else if (neg_reg)
                begin
                    kind_next = KIND_NULL;
                    neg_next  = 1'b0;
                    if (inside_reg)
                    begin
                        items_next  = items_dec;
                        inside_next = items_dec != '0;
                    end
                end
                else
                begin
                    bulk_rem_next = accum_reg;
                end
            end
            PH_LINE_LF, PH_BULK_LF:
            begin
                if (inside_reg)
                begin
                    items_next  = items_dec;
                    inside_next = items_dec != '0;
                end
            end
            PH_BULK_FIRST, PH_BULK:
            begin
                if (bulk_nz)
                begin
                    bulk_rem_next = bulk_rem_reg - LEN_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (fail)
        begin
            accum_next    = '0;
            neg_next      = 1'b0;
            bulk_rem_next = '0;
            items_next    = '0;
            inside_next   = 1'b0;
            kind_next     = KIND_SIMPLE;
            hdr_next      = 1'b0;
        end
    end

    // result word
    always_comb
    begin
        res_next               = '0;
        res_next.kind          = kind_next;
        res_next.in_array_item = inside_next && !hdr_next;
        unique case (phase_reg)
            PH_LINE_FIRST, PH_LINE:
            begin
                res_next.elem_start = phase_reg == PH_LINE_FIRST;
                if (word.cls != CH_CR)
                begin
                    res_next.data          = word.data;
                    res_next.payload_valid = 1'b1;
                end
            end
            PH_LINE_LF, PH_BULK_LF:
            begin
                res_next.kind          = kind_reg;
                res_next.elem_end      = 1'b1;
                res_next.in_array_item = inside_reg;
                res_next.msg_end       = fin_msg;
            end
            PH_NUM_LF:
            begin
                if (hdr_reg)
                begin
                    res_next.kind          = KIND_SIMPLE;
                    res_next.in_array_item = 1'b0;
                    res_next.array_header  = 1'b1;
                    res_next.array_count   = ARRAY_COUNT_W'(cnt64);
                    res_next.msg_end       = cnt_zero;
                end
                else if (neg_reg)
                begin
                    res_next.kind          = KIND_NULL;
                    res_next.elem_start    = 1'b1;
                    res_next.elem_end      = 1'b1;
                    res_next.in_array_item = inside_reg;
                    res_next.msg_end       = fin_msg;
                end
            end
            PH_BULK_FIRST, PH_BULK:
            begin
                res_next.elem_start = phase_reg == PH_BULK_FIRST;
                if (bulk_nz)
                begin
                    res_next.data          = word.data;
                    res_next.payload_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (fail)
        begin
            res_next           = '0;
            res_next.bad_frame = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            accum_reg     <= '0;
            neg_reg       <= 1'b0;
            bulk_rem_reg  <= '0;
            items_reg     <= '0;
            inside_reg    <= 1'b0;
            kind_reg      <= KIND_SIMPLE;
            hdr_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                accum_reg    <= accum_next;
                neg_reg      <= neg_next;
                bulk_rem_reg <= bulk_rem_next;
                items_reg    <= items_next;
                inside_reg   <= inside_next;
                kind_reg     <= kind_next;
                hdr_reg      <= hdr_next;
            end
            if (word_ready)
            begin
                res_valid_reg <= word_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bulk_reg  <= MAX_BULK_RST;
            max_array_reg <= MAX_ARRAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_BULK_LEN:
                begin
                    max_bulk_reg <= cfg_data[MAX_BULK_W-1:0];
                end
                CFG_MAX_ARRAY_COUNT:
                begin
                    max_array_reg <= cfg_data[MAX_ARRAY_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    `RSP_ASSERT_NXT(a_fail_resync, pop && fail, phase_reg == PH_IDLE && !inside_reg && !hdr_reg)
    `RSP_ASSERT_IMP(a_inside_has_items, inside_reg, items_reg != '0)
    `RSP_ASSERT_IMP(a_hdr_in_number, hdr_reg, num_phase)
    `RSP_ASSERT_NXT(a_result_held, res_valid_reg && !result_ready, res_valid_reg && $stable(res_reg))
endmodule

// ===== rtl/resp_stream_parser_core.sv =====
// Top level of the RESP stream parser: front classifier, word queue, parse back end.
//
//  channel     dir   payload
//  byte_ch     sink  in_byte
//  result_ch   src   out_byte, payload_valid, elem_kind, elem_start, elem_end,
//                    in_array_item, array_header, array_count, msg_end, bad_frame
//  cfg         wr    cfg_we, cfg_index, cfg_data
//
// One result word per byte word; sustained rate one word per cycle when neither side stalls.
// Each word passes the front register, the queue and the result register, in that order.
// The phase machine and counters in the back end update once per word.
// Reset clears all parse state and loads the default limits.
// Either side may stall; the queue decouples front and back.
module resp_stream_parser_core #(
    parameter int LEN_BITS   = rsp_pkg::LEN_BITS_DEF,
    parameter int COUNT_BITS = rsp_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rsp_in_if.sink                         byte_ch,
    rsp_out_if.source                      result_ch,
    input  logic                           cfg_we,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rsp_pkg::*;

    rsp_word_t   front_word;
    logic        front_valid;
    logic        front_ready;
    rsp_word_t   queue_word;
    logic        queue_valid;
    logic        queue_ready;
    rsp_result_t result;

    rsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (byte_ch.in_byte),
        .in_valid   (byte_ch.valid),
        .in_ready   (byte_ch.ready),
        .word       (front_word),
        .word_valid (front_valid),
        .word_ready (front_ready)
    );

    rsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (front_word),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_word   (queue_word),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    rsp_back #(
        .LEN_BITS   (LEN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .word         (queue_word),
        .word_valid   (queue_valid),
        .word_ready   (queue_ready),
        .result       (result),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    assign result_ch.out_byte      = result.data;
    assign result_ch.payload_valid = result.payload_valid;
    assign result_ch.elem_kind     = result.kind;
    assign result_ch.elem_start    = result.elem_start;
    assign result_ch.elem_end      = result.elem_end;
    assign result_ch.in_array_item = result.in_array_item;
    assign result_ch.array_header  = result.array_header;
    assign result_ch.array_count   = result.array_count;
    assign result_ch.msg_end       = result.msg_end;
    assign result_ch.bad_frame     = result.bad_frame;
endmodule
